>>> hw/rtl/pcc_pkg.sv
// Shared widths, state codes and controller/datapath command types for the collision block.
package pcc_pkg;

  localparam int COORD_W  = 24;               // vertex and centre coordinates
  localparam int RAD_W    = COORD_W - 1;      // radius and depth
  localparam int DIR_W    = COORD_W + 1;      // direction vectors
  localparam int EDGE_W   = COORD_W + 1;      // edge vector and centre offset
  localparam int LEN2_W   = 2 * EDGE_W;       // squared edge length
  localparam int DOT_W    = 2 * EDGE_W + 1;   // signed dot product
  localparam int DOT_LO_W = EDGE_W + 1;       // low slice of dot, unsigned
  localparam int NUM_W    = EDGE_W + DOT_W;   // edge component times dot
  localparam int ACC_W    = NUM_W + 2;        // accumulator
  localparam int QUOT_W   = COORD_W + 3;      // rounded foot offset
  localparam int HIT_W    = COORD_W + 3;      // unsaturated foot coordinate
  localparam int DIFF_W   = COORD_W + 4;      // foot minus circle centre
  localparam int D2_W     = 2 * DIFF_W;       // squared foot distance
  localparam int MUL_W    = DIFF_W + 1;       // multiplier operand
  localparam int PROD_W   = 2 * MUL_W;        // multiplier product
  localparam int SQ_OUT_W = D2_W / 2;         // root width
  localparam int CMP_W    = DOT_W + 2;        // range test width

  typedef enum logic [5:0] {
    ST_IDLE, ST_SETUP, ST_LEN0, ST_LEN1, ST_LEN2, ST_DOT0, ST_DOT1,
    ST_NX0, ST_NX1, ST_NX2, ST_NX3, ST_DVX, ST_DVXW, ST_HX,
    ST_NY1, ST_NY2, ST_NY3, ST_DVY, ST_DVYW, ST_HY,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_SQW, ST_RL0, ST_RL1, ST_RL2,
    ST_NEXT, ST_FSQ, ST_FSQW, ST_LOAD
  } ctl_state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_EX_EX, MUL_EY_EY, MUL_EX_CX, MUL_EY_CY,
    MUL_EX_DLO, MUL_EX_DHI, MUL_EY_DLO, MUL_EY_DHI,
    MUL_DX_DX, MUL_DY_DY, MUL_R_R, MUL_R_L
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_SH
  } acc_op_t;

  typedef struct packed {
    logic     load_item;
    logic     first_item;
    logic     setup_edge;
    logic     edge_sel;     // 0: previous to current, 1: current to first
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     store_len2;
    logic     store_dot;
    logic     div_start;
    logic     store_hx;
    logic     store_hy;
    logic     store_d2;
    logic     sqrt_start;
    logic     sqrt_sel;     // 0: squared edge length, 1: best distance
    logic     set_err;
    logic     try_best;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic len2_zero;
    logic d2_lt_r2;
    logic div_done;
    logic sqrt_done;
    logic out_busy;
  } sts_t;

endpackage

>>> hw/rtl/pcc_if.sv
// Valid/ready channel interfaces for vertex items and result items.
interface pcc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pcc_pkg::COORD_W-1:0]   vertex_x;
  logic signed [pcc_pkg::COORD_W-1:0]   vertex_y;
  logic                                 last_vertex;
  logic signed [pcc_pkg::COORD_W-1:0]   circle_x;
  logic signed [pcc_pkg::COORD_W-1:0]   circle_y;
  logic        [pcc_pkg::RAD_W-1:0]     circle_radius;
  logic signed [pcc_pkg::COORD_W-1:0]   poly_center_x;
  logic signed [pcc_pkg::COORD_W-1:0]   poly_center_y;

  modport source (output valid, vertex_x, vertex_y, last_vertex, circle_x, circle_y,
                  circle_radius, poly_center_x, poly_center_y, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, circle_x, circle_y,
                circle_radius, poly_center_x, poly_center_y, output ready);
endinterface

interface pcc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic                                 degenerate_edge;
  logic signed [pcc_pkg::COORD_W-1:0]   contact_x;
  logic signed [pcc_pkg::COORD_W-1:0]   contact_y;
  logic signed [pcc_pkg::DIR_W-1:0]     poly_dir_x;
  logic signed [pcc_pkg::DIR_W-1:0]     poly_dir_y;
  logic signed [pcc_pkg::DIR_W-1:0]     circle_dir_x;
  logic signed [pcc_pkg::DIR_W-1:0]     circle_dir_y;
  logic        [pcc_pkg::RAD_W-1:0]     depth;

  modport source (output valid, hit, degenerate_edge, contact_x, contact_y, poly_dir_x,
                  poly_dir_y, circle_dir_x, circle_dir_y, depth, input ready);
  modport sink (input valid, hit, degenerate_edge, contact_x, contact_y, poly_dir_x,
                poly_dir_y, circle_dir_x, circle_dir_y, depth, output ready);
endinterface

>>> hw/rtl/pcc_div.sv
// Restoring divider, one quotient bit per cycle, rounded to nearest with halves away from zero.
module pcc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [pcc_pkg::NUM_W-1:0]     numer,
  input  logic        [pcc_pkg::LEN2_W-1:0]    denom,
  output logic                                 done,
  output logic signed [pcc_pkg::QUOT_W-1:0]    quot
);
  import pcc_pkg::*;

  localparam int SH_W  = NUM_W - LEN2_W;
  localparam int CNT_W = $clog2(SH_W + 1);

  logic                     busy_r, busy_nxt;
  logic                     fin_r, fin_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [NUM_W-1:0]         rem_r, rem_nxt;
  logic [NUM_W-1:0]         dsh_r, dsh_nxt;
  logic [LEN2_W-1:0]        den_r, den_nxt;
  logic [QUOT_W-1:0]        q_r, q_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [QUOT_W-1:0] quot_r, quot_nxt;
  logic [QUOT_W-1:0]        mag;

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    quot_nxt = quot_r;
    mag      = q_r + QUOT_W'({rem_r[LEN2_W-1:0], 1'b0} >= {1'b0, den_r});
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = numer[NUM_W-1];
      rem_nxt  = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
      dsh_nxt  = {denom, SH_W'(0)};
      den_nxt  = denom;
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(SH_W);
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[QUOT_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QUOT_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (fin_r) begin
      quot_nxt = neg_r ? -$signed(mag) : $signed(mag);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule

>>> hw/rtl/pcc_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
module pcc_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pcc_pkg::D2_W-1:0]          radicand,
  output logic                              done,
  output logic [pcc_pkg::SQ_OUT_W-1:0]      root
);
  import pcc_pkg::*;

  localparam int REM_W = SQ_OUT_W + 2;
  localparam int CNT_W = $clog2(SQ_OUT_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [D2_W-1:0]       n_r, n_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [SQ_OUT_W-1:0]   root_r, root_nxt;
  logic [REM_W+1:0]      rem_t;
  logic [REM_W+1:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_t    = {rem_r, n_r[D2_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      n_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(SQ_OUT_W - 1);
    end else if (busy_r) begin
      n_nxt = {n_r[D2_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = REM_W'(rem_t - trial);
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_t);
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

>>> hw/rtl/pcc_datapath.sv
// Datapath: polygon state, shared multiplier and accumulator, divider, root unit, result register.
module pcc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcc_pkg::cmd_t                      cmd,
  output pcc_pkg::sts_t                      sts,
  input  logic signed [pcc_pkg::COORD_W-1:0] vertex_x,
  input  logic signed [pcc_pkg::COORD_W-1:0] vertex_y,
  input  logic signed [pcc_pkg::COORD_W-1:0] circle_x,
  input  logic signed [pcc_pkg::COORD_W-1:0] circle_y,
  input  logic        [pcc_pkg::RAD_W-1:0]   circle_radius,
  input  logic signed [pcc_pkg::COORD_W-1:0] poly_center_x,
  input  logic signed [pcc_pkg::COORD_W-1:0] poly_center_y,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               hit,
  output logic                               degenerate_edge,
  output logic signed [pcc_pkg::COORD_W-1:0] contact_x,
  output logic signed [pcc_pkg::COORD_W-1:0] contact_y,
  output logic signed [pcc_pkg::DIR_W-1:0]   poly_dir_x,
  output logic signed [pcc_pkg::DIR_W-1:0]   poly_dir_y,
  output logic signed [pcc_pkg::DIR_W-1:0]   circle_dir_x,
  output logic signed [pcc_pkg::DIR_W-1:0]   circle_dir_y,
  output logic        [pcc_pkg::RAD_W-1:0]   depth
);
  import pcc_pkg::*;

  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] sat_c(input logic signed [HIT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > HIT_W'(C_MAX))      r = C_MAX;
    else if (v < HIT_W'(C_MIN)) r = C_MIN;
    else                        r = v[COORD_W-1:0];
    return r;
  endfunction

  // polygon state
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic signed [COORD_W-1:0] cir_x_r, cir_y_r, pc_x_r, pc_y_r;
  logic        [RAD_W-1:0]   rad_r;
  logic                      found_r, err_r;
  logic signed [COORD_W-1:0] best_x_r, best_y_r;
  logic        [D2_W-1:0]    best_d2_r;

  // edge working registers
  logic signed [COORD_W-1:0] ax_r, ay_r;
  logic signed [EDGE_W-1:0]  ex_r, ey_r, cx_r, cy_r;
  logic        [LEN2_W-1:0]  len2_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic signed [HIT_W-1:0]   hx_r, hy_r;
  logic        [D2_W-1:0]    d2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  // result register
  logic                      out_valid_r;
  logic                      hit_r, degen_r;
  logic signed [COORD_W-1:0] cont_x_r, cont_y_r;
  logic signed [DIR_W-1:0]   pdir_x_r, pdir_y_r, cdir_x_r, cdir_y_r;
  logic        [RAD_W-1:0]   depth_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [COORD_W-1:0] sel_ax, sel_ay, sel_bx, sel_by;
  logic signed [CMP_W-1:0]   rl, dot_c, len2_c;
  logic                      in_range;
  logic                      div_done, sq_done;
  logic signed [QUOT_W-1:0]  quot;
  logic [SQ_OUT_W-1:0]       root;
  logic [D2_W-1:0]           sq_in;

  assign dx = DIFF_W'(hx_r) - DIFF_W'(cir_x_r);
  assign dy = DIFF_W'(hy_r) - DIFF_W'(cir_y_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_EX_EX:  begin mul_a = MUL_W'(ex_r); mul_b = MUL_W'(ex_r); end
      MUL_EY_EY:  begin mul_a = MUL_W'(ey_r); mul_b = MUL_W'(ey_r); end
      MUL_EX_CX:  begin mul_a = MUL_W'(ex_r); mul_b = MUL_W'(cx_r); end
      MUL_EY_CY:  begin mul_a = MUL_W'(ey_r); mul_b = MUL_W'(cy_r); end
      MUL_EX_DLO: begin
        mul_a = MUL_W'(ex_r);
        mul_b = MUL_W'($signed({1'b0, dot_r[DOT_LO_W-1:0]}));
      end
      MUL_EX_DHI: begin
        mul_a = MUL_W'(ex_r);
        mul_b = MUL_W'($signed(dot_r[DOT_W-1:DOT_LO_W]));
      end
      MUL_EY_DLO: begin
        mul_a = MUL_W'(ey_r);
        mul_b = MUL_W'($signed({1'b0, dot_r[DOT_LO_W-1:0]}));
      end
      MUL_EY_DHI: begin
        mul_a = MUL_W'(ey_r);
        mul_b = MUL_W'($signed(dot_r[DOT_W-1:DOT_LO_W]));
      end
      MUL_DX_DX:  begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
      MUL_DY_DY:  begin mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); end
      MUL_R_R: begin
        mul_a = MUL_W'($signed({1'b0, rad_r}));
        mul_b = MUL_W'($signed({1'b0, rad_r}));
      end
      MUL_R_L: begin
        mul_a = MUL_W'($signed({1'b0, rad_r}));
        mul_b = MUL_W'($signed({1'b0, root[EDGE_W-1:0]}));
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD:   acc_nxt = ACC_W'(prod_r);
      ACC_ADD:    acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_ADD_SH: acc_nxt = acc_r + (ACC_W'(prod_r) <<< DOT_LO_W);
      default:    acc_nxt = acc_r;
    endcase
  end

  assign sel_ax = cmd.edge_sel ? cur_x_r   : prev_x_r;
  assign sel_ay = cmd.edge_sel ? cur_y_r   : prev_y_r;
  assign sel_bx = cmd.edge_sel ? first_x_r : cur_x_r;
  assign sel_by = cmd.edge_sel ? first_y_r : cur_y_r;

  // range test: -r*L <= dot <= len^2 + r*L, with r*L in the accumulator
  assign rl       = acc_r[CMP_W-1:0];
  assign dot_c    = CMP_W'(dot_r);
  assign len2_c   = CMP_W'($signed({1'b0, len2_r}));
  assign in_range = (dot_c >= -rl) && (dot_c <= len2_c + rl);

  assign sq_in = cmd.sqrt_sel ? best_d2_r : D2_W'(len2_r);

  pcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .numer (acc_r[NUM_W-1:0]),
    .denom (len2_r),
    .done  (div_done),
    .quot  (quot)
  );

  pcc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item && cmd.first_item) begin
        found_r <= 1'b0;
        err_r   <= 1'b0;
      end
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.try_best && in_range && (!found_r || d2_r < best_d2_r)) found_r <= 1'b1;
      if (cmd.load_out)              out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end

    if (cmd.load_item) begin
      cur_x_r <= vertex_x;
      cur_y_r <= vertex_y;
      pc_x_r  <= poly_center_x;
      pc_y_r  <= poly_center_y;
      if (cmd.first_item) begin
        first_x_r <= vertex_x;
        first_y_r <= vertex_y;
        prev_x_r  <= vertex_x;
        prev_y_r  <= vertex_y;
        cir_x_r   <= circle_x;
        cir_y_r   <= circle_y;
        rad_r     <= circle_radius;
        best_x_r  <= '0;
        best_y_r  <= '0;
        best_d2_r <= '0;
      end
    end

    if (cmd.setup_edge) begin
      ax_r <= sel_ax;
      ay_r <= sel_ay;
      ex_r <= EDGE_W'(sel_bx) - EDGE_W'(sel_ax);
      ey_r <= EDGE_W'(sel_by) - EDGE_W'(sel_ay);
      cx_r <= EDGE_W'(cir_x_r) - EDGE_W'(sel_ax);
      cy_r <= EDGE_W'(cir_y_r) - EDGE_W'(sel_ay);
      // open edge done with the previous vertex: advance it
      if (!cmd.edge_sel) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
      end
    end

    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    if (cmd.store_len2) len2_r <= acc_r[LEN2_W-1:0];
    if (cmd.store_dot)  dot_r  <= acc_r[DOT_W-1:0];
    if (cmd.store_hx)   hx_r   <= HIT_W'(ax_r) + HIT_W'(quot);
    if (cmd.store_hy)   hy_r   <= HIT_W'(ay_r) + HIT_W'(quot);
    if (cmd.store_d2)   d2_r   <= acc_r[D2_W-1:0];

    if (cmd.try_best && in_range && (!found_r || d2_r < best_d2_r)) begin
      best_d2_r <= d2_r;
      best_x_r  <= sat_c(hx_r);
      best_y_r  <= sat_c(hy_r);
    end

    if (cmd.load_out) begin
      if (found_r && !err_r) begin
        hit_r    <= 1'b1;
        degen_r  <= 1'b0;
        cont_x_r <= best_x_r;
        cont_y_r <= best_y_r;
        pdir_x_r <= DIR_W'(pc_x_r) - DIR_W'(best_x_r);
        pdir_y_r <= DIR_W'(pc_y_r) - DIR_W'(best_y_r);
        cdir_x_r <= DIR_W'(cir_x_r) - DIR_W'(best_x_r);
        cdir_y_r <= DIR_W'(cir_y_r) - DIR_W'(best_y_r);
        depth_r  <= rad_r - root[RAD_W-1:0];
      end else begin
        // miss or degenerate polygon: clear every field but the error flag
        hit_r    <= 1'b0;
        degen_r  <= err_r;
        cont_x_r <= '0;
        cont_y_r <= '0;
        pdir_x_r <= '0;
        pdir_y_r <= '0;
        cdir_x_r <= '0;
        cdir_y_r <= '0;
        depth_r  <= '0;
      end
    end
  end

  assign sts.len2_zero = (len2_r == '0);
  assign sts.d2_lt_r2  = (d2_r < acc_r[D2_W-1:0]);
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sq_done;
  assign sts.out_busy  = out_valid_r;

  assign out_valid       = out_valid_r;
  assign hit             = hit_r;
  assign degenerate_edge = degen_r;
  assign contact_x       = cont_x_r;
  assign contact_y       = cont_y_r;
  assign poly_dir_x      = pdir_x_r;
  assign poly_dir_y      = pdir_y_r;
  assign circle_dir_x    = cdir_x_r;
  assign circle_dir_y    = cdir_y_r;
  assign depth           = depth_r;
endmodule

>>> hw/rtl/pcc_ctrl.sv
// Controller: sequences each edge through the shared datapath units.
module pcc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  pcc_pkg::sts_t  sts,
  output pcc_pkg::cmd_t  cmd
);
  import pcc_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       edge_r, edge_nxt;
  logic       last_r, last_nxt;
  logic       in_poly_r, in_poly_nxt;

  always_comb begin
    state_nxt   = state_r;
    edge_nxt    = edge_r;
    last_nxt    = last_r;
    in_poly_nxt = in_poly_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt    = in_last;
          in_poly_nxt = 1'b1;
          if (in_poly_r) begin
            edge_nxt  = 1'b0;
            state_nxt = ST_SETUP;
          end else if (in_last) begin
            edge_nxt  = 1'b1;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: state_nxt = ST_LEN0;
      ST_LEN0:  state_nxt = ST_LEN1;
      ST_LEN1:  state_nxt = ST_LEN2;
      ST_LEN2:  state_nxt = ST_DOT0;
      ST_DOT0:  state_nxt = ST_DOT1;
      ST_DOT1:  state_nxt = sts.len2_zero ? ST_NEXT : ST_NX0;
      ST_NX0:   state_nxt = ST_NX1;
      ST_NX1:   state_nxt = ST_NX2;
      ST_NX2:   state_nxt = ST_NX3;
      ST_NX3:   state_nxt = ST_DVX;
      ST_DVX:   state_nxt = ST_DVXW;
      ST_DVXW:  if (sts.div_done) state_nxt = ST_HX;
      ST_HX:    state_nxt = ST_NY1;
      ST_NY1:   state_nxt = ST_NY2;
      ST_NY2:   state_nxt = ST_NY3;
      ST_NY3:   state_nxt = ST_DVY;
      ST_DVY:   state_nxt = ST_DVYW;
      ST_DVYW:  if (sts.div_done) state_nxt = ST_HY;
      ST_HY:    state_nxt = ST_D0;
      ST_D0:    state_nxt = ST_D1;
      ST_D1:    state_nxt = ST_D2;
      ST_D2:    state_nxt = ST_D3;
      ST_D3:    state_nxt = ST_D4;
      ST_D4:    state_nxt = sts.d2_lt_r2 ? ST_SQW : ST_NEXT;
      ST_SQW:   if (sts.sqrt_done) state_nxt = ST_RL0;
      ST_RL0:   state_nxt = ST_RL1;
      ST_RL1:   state_nxt = ST_RL2;
      ST_RL2:   state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (!edge_r && last_r) begin
          edge_nxt  = 1'b1;
          state_nxt = ST_SETUP;
        end else if (last_r) begin
          state_nxt = ST_FSQ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FSQ:   state_nxt = ST_FSQW;
      ST_FSQW:  if (sts.sqrt_done) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (!sts.out_busy) begin
          in_poly_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_NONE;
    cmd.acc_op   = ACC_HOLD;
    cmd.edge_sel = edge_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_item  = in_valid;
        cmd.first_item = !in_poly_r;
      end
      ST_SETUP: cmd.setup_edge = 1'b1;
      ST_LEN0:  cmd.mul_sel = MUL_EX_EX;
      ST_LEN1:  begin cmd.mul_sel = MUL_EY_EY; cmd.acc_op = ACC_LOAD; end
      ST_LEN2:  begin cmd.mul_sel = MUL_EX_CX; cmd.acc_op = ACC_ADD; end
      ST_DOT0: begin
        cmd.mul_sel    = MUL_EY_CY;
        cmd.acc_op     = ACC_LOAD;
        cmd.store_len2 = 1'b1;
      end
      ST_DOT1: begin
        cmd.acc_op  = ACC_ADD;
        cmd.set_err = sts.len2_zero;
      end
      ST_NX0:   cmd.store_dot = 1'b1;
      ST_NX1:   cmd.mul_sel = MUL_EX_DLO;
      ST_NX2:   begin cmd.mul_sel = MUL_EX_DHI; cmd.acc_op = ACC_LOAD; end
      ST_NX3:   cmd.acc_op = ACC_ADD_SH;
      ST_DVX:   cmd.div_start = 1'b1;
      ST_HX:    cmd.store_hx = 1'b1;
      ST_NY1:   cmd.mul_sel = MUL_EY_DLO;
      ST_NY2:   begin cmd.mul_sel = MUL_EY_DHI; cmd.acc_op = ACC_LOAD; end
      ST_NY3:   cmd.acc_op = ACC_ADD_SH;
      ST_DVY:   cmd.div_start = 1'b1;
      ST_HY:    cmd.store_hy = 1'b1;
      ST_D0:    cmd.mul_sel = MUL_DX_DX;
      ST_D1:    begin cmd.mul_sel = MUL_DY_DY; cmd.acc_op = ACC_LOAD; end
      ST_D2:    begin cmd.mul_sel = MUL_R_R; cmd.acc_op = ACC_ADD; end
      ST_D3:    begin cmd.acc_op = ACC_LOAD; cmd.store_d2 = 1'b1; end
      ST_D4:    cmd.sqrt_start = sts.d2_lt_r2;
      ST_RL0:   cmd.mul_sel = MUL_R_L;
      ST_RL1:   cmd.acc_op = ACC_LOAD;
      ST_RL2:   cmd.try_best = 1'b1;
      ST_FSQ:   begin cmd.sqrt_start = 1'b1; cmd.sqrt_sel = 1'b1; end
      ST_LOAD:  cmd.load_out = !sts.out_busy;
      default:  cmd.mul_sel = MUL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      edge_r    <= 1'b0;
      last_r    <= 1'b0;
      in_poly_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      edge_r    <= edge_nxt;
      last_r    <= last_nxt;
      in_poly_r <= in_poly_nxt;
    end
  end
endmodule

>>> hw/rtl/polygon_circle_collision.sv
// Top level of the convex polygon versus circle contact detector.
//
//   Channel    Dir   Handshake             Carries
//   in_item    in    valid/ready (sink)    one polygon vertex, circle and centre fields
//   out_item   out   valid/ready (source)  hit, degenerate flag, contact, directions, depth
//
// Flow: one vertex item at a time. A first vertex that is not last is only stored.
// Each edge runs setup and multiply/accumulate steps plus two divisions (one per foot
// coordinate); when the foot is inside the radius, a root of the squared length and a
// range test follow. A zero-length edge ends after its length step and sets the error
// flag. The last vertex runs the open edge and the closing edge (a lone vertex only the
// closing edge), then the depth root and the result load.
// Reset is synchronous, active low; it clears control state only.
// The result sits in an output register; the next polygon is accepted while it waits,
// and only its own result load stalls until the register is free.
module polygon_circle_collision (
  input  logic clk,
  input  logic rst_n,
  pcc_in_if.sink    in_item,
  pcc_out_if.source out_item
);
  import pcc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the input handshake and walks each edge
  pcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_last  (in_item.last_vertex),
    .in_ready (in_item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, polygon state and the result register
  pcc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .vertex_x        (in_item.vertex_x),
    .vertex_y        (in_item.vertex_y),
    .circle_x        (in_item.circle_x),
    .circle_y        (in_item.circle_y),
    .circle_radius   (in_item.circle_radius),
    .poly_center_x   (in_item.poly_center_x),
    .poly_center_y   (in_item.poly_center_y),
    .out_ready       (out_item.ready),
    .out_valid       (out_item.valid),
    .hit             (out_item.hit),
    .degenerate_edge (out_item.degenerate_edge),
    .contact_x       (out_item.contact_x),
    .contact_y       (out_item.contact_y),
    .poly_dir_x      (out_item.poly_dir_x),
    .poly_dir_y      (out_item.poly_dir_y),
    .circle_dir_x    (out_item.circle_dir_x),
    .circle_dir_y    (out_item.circle_dir_y),
    .depth           (out_item.depth)
  );
endmodule

>>> tb/polygon_circle_collision_test.sv
// Self-checking testbench for the polygon versus circle contact detector.
`timescale 1ns / 100ps

module polygon_circle_collision_test;
  import pcc_pkg::*;

  localparam int    RAND_ITEMS = 830;
  localparam longint CMAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  typedef struct {
    logic signed [COORD_W-1:0] vx, vy;
    logic                      last;
    logic signed [COORD_W-1:0] cx, cy;
    logic [RAD_W-1:0]          rad;
    logic signed [COORD_W-1:0] pcx, pcy;
  } vertex_t;

  typedef struct packed {
    logic                      hit;
    logic                      degenerate_edge;
    logic signed [COORD_W-1:0] contact_x, contact_y;
    logic signed [DIR_W-1:0]   poly_dir_x, poly_dir_y, circle_dir_x, circle_dir_y;
    logic [RAD_W-1:0]          depth;
  } contact_t;

  // Directed table row: a vertex, plus an optional typed-in result.
  typedef struct {
    vertex_t  v;
    logic     fixed;
    contact_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  pcc_in_if  in_item();
  pcc_out_if out_item();

  polygon_circle_collision dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item.sink),
    .out_item (out_item.source)
  );

  // Contact predictor state
  longint   first_x, first_y, prev_x, prev_y;
  logic     open_poly;
  longint   circ_x, circ_y, circ_r;
  logic     have_hit;
  longint   near_x, near_y, near_d2;
  logic     zero_edge;

  contact_t contact_q[$];
  row_t     table_rows[$];
  int       mismatches = 0;
  int       in_idle = 22;
  int       out_idle = 22;

  function automatic longint clamp_coord(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic longint floor_root(logic [127:0] n);
    logic [127:0] res, cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= n) res = cand;
    end
    return longint'(res);
  endfunction

  // Divide by a positive value, round half away from zero.
  function automatic longint round_div(logic signed [127:0] n, logic [127:0] d);
    logic         neg;
    logic [127:0] m, q, r;
    neg = n < 0;
    m = neg ? -n : n;
    q = m / d;
    r = m % d;
    if ((r << 1) >= d) q = q + 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void try_edge(longint ax, longint ay, longint bx, longint by);
    longint ex, ey, ox, oy, len2, dot, hx, hy, dx, dy, d2, rl;
    logic signed [127:0] nx, ny;
    ex = bx - ax;  ey = by - ay;
    ox = circ_x - ax;  oy = circ_y - ay;
    len2 = ex * ex + ey * ey;
    if (len2 == 0) begin
      zero_edge = 1'b1;
      return;
    end
    dot = ex * ox + ey * oy;
    nx = 128'(signed'(ex)) * 128'(signed'(dot));
    ny = 128'(signed'(ey)) * 128'(signed'(dot));
    hx = ax + round_div(nx, 128'(len2));
    hy = ay + round_div(ny, 128'(len2));
    dx = hx - circ_x;  dy = hy - circ_y;
    d2 = dx * dx + dy * dy;
    if (d2 >= circ_r * circ_r) return;
    rl = circ_r * floor_root(128'(len2));
    if (dot < -rl || dot > len2 + rl) return;
    if (!have_hit || d2 < near_d2) begin
      have_hit = 1'b1;
      near_d2 = d2;
      near_x = clamp_coord(hx);
      near_y = clamp_coord(hy);
    end
  endfunction

  // Advance the predictor by one item; returns 1 with a result on the last vertex.
  function automatic bit predict_contact(vertex_t v, output contact_t c);
    c = '0;
    if (!open_poly) begin
      first_x = v.vx;  first_y = v.vy;
      prev_x = v.vx;   prev_y = v.vy;
      circ_x = v.cx;   circ_y = v.cy;   circ_r = v.rad;
      have_hit = 1'b0;  near_x = 0;  near_y = 0;  near_d2 = 0;
      zero_edge = 1'b0;
      open_poly = 1'b1;
    end else begin
      try_edge(prev_x, prev_y, v.vx, v.vy);
      prev_x = v.vx;  prev_y = v.vy;
    end
    if (!v.last) return 0;
    try_edge(v.vx, v.vy, first_x, first_y);
    if (zero_edge) begin
      c.degenerate_edge = 1'b1;
    end else if (have_hit) begin
      c.hit = 1'b1;
      c.contact_x = COORD_W'(near_x);
      c.contact_y = COORD_W'(near_y);
      c.poly_dir_x = DIR_W'(longint'(v.pcx) - near_x);
      c.poly_dir_y = DIR_W'(longint'(v.pcy) - near_y);
      c.circle_dir_x = DIR_W'(circ_x - near_x);
      c.circle_dir_y = DIR_W'(circ_y - near_y);
      c.depth = RAD_W'(circ_r - floor_root(128'(near_d2)));
    end
    open_poly = 1'b0;
    return 1;
  endfunction

  // Drive one item: random idle cycles, then hold valid until it is taken.
  task automatic send_vertex(vertex_t v, logic fixed, contact_t fixed_res);
    contact_t c;
    while ($urandom_range(99) < in_idle) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.vertex_x <= v.vx;
    in_item.vertex_y <= v.vy;
    in_item.last_vertex <= v.last;
    in_item.circle_x <= v.cx;
    in_item.circle_y <= v.cy;
    in_item.circle_radius <= v.rad;
    in_item.poly_center_x <= v.pcx;
    in_item.poly_center_y <= v.pcy;
    do @(posedge clk); while (!in_item.ready);
    if (predict_contact(v, c)) contact_q.push_back(fixed ? fixed_res : c);
  endtask

  function automatic vertex_t mk(longint x, longint y, bit last, longint cx = 0,
                                 longint cy = 0, longint r = 0, longint px = 0,
                                 longint py = 0);
    vertex_t v;
    v.vx = COORD_W'(x);  v.vy = COORD_W'(y);  v.last = last;
    v.cx = COORD_W'(cx);  v.cy = COORD_W'(cy);  v.rad = RAD_W'(r);
    v.pcx = COORD_W'(px);  v.pcy = COORD_W'(py);
    return v;
  endfunction

  task automatic add_row(vertex_t v, logic fixed = 1'b0, contact_t res = '0);
    row_t r;
    r.v = v;  r.fixed = fixed;  r.res = res;
    table_rows.push_back(r);
  endtask

  function automatic longint rnd_coord();
    return longint'(signed'(COORD_W'($urandom())));
  endfunction

  // Well-formed polygon with the circle placed near it; mostly small coordinates.
  task automatic send_polygon(ref int count);
    int     n, scale, span;
    longint pcx, pcy, ccx, ccy, rad, x, y;
    real    ang, a0;
    vertex_t v;
    n = $urandom_range(7, 1) + ($urandom_range(9) == 0 ? 0 : 1);
    scale = ($urandom_range(9) == 0) ? 21 : $urandom_range(14, 4);
    span = 1 << scale;
    pcx = clamp_coord(rnd_coord() >>> (COORD_W - 1 - scale + 2));
    pcy = clamp_coord(rnd_coord() >>> (COORD_W - 1 - scale + 2));
    ccx = clamp_coord(pcx + $signed($urandom_range(2 * span)) - span);
    ccy = clamp_coord(pcy + $signed($urandom_range(2 * span)) - span);
    rad = $urandom_range(span, 0);
    if ($urandom_range(19) == 0) rad = $urandom_range(CMAX, 0);
    a0 = $urandom_range(359) * 3.14159265 / 180.0;
    for (int i = 0; i < n; i++) begin
      ang = a0 + 6.2831853 * i / n;
      x = clamp_coord(pcx + longint'(span * $cos(ang)) + $urandom_range(3) - 1);
      y = clamp_coord(pcy + longint'(span * $sin(ang)) + $urandom_range(3) - 1);
      if (i > 0 && $urandom_range(29) == 0) begin
        x = v.vx;  y = v.vy;   // repeat a vertex: zero-length edge
      end
      v = mk(x, y, i == n - 1, ccx, ccy, rad, pcx, pcy);
      if (i > 0) begin
        v.cx = COORD_W'(rnd_coord());  v.cy = COORD_W'(rnd_coord());
        v.rad = RAD_W'($urandom());
      end
      if (i < n - 1) begin
        v.pcx = COORD_W'(rnd_coord());  v.pcy = COORD_W'(rnd_coord());
      end
      send_vertex(v, 1'b0, '0);
      count++;
    end
  endtask

  // Result side: random backpressure, compare each item with the oldest expectation.
  always @(posedge clk) begin
    contact_t got, want;
    if (!rst_n) begin
      out_item.ready <= 1'b0;
    end else begin
      out_item.ready <= ($urandom_range(99) >= out_idle);
      if (out_item.valid && out_item.ready) begin
        got = '{out_item.hit, out_item.degenerate_edge, out_item.contact_x,
                out_item.contact_y, out_item.poly_dir_x, out_item.poly_dir_y,
                out_item.circle_dir_x, out_item.circle_dir_y, out_item.depth};
        if (contact_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          want = contact_q.pop_front();
          if (got.hit !== want.hit || got.degenerate_edge !== want.degenerate_edge ||
              got.contact_x !== want.contact_x || got.contact_y !== want.contact_y ||
              got.poly_dir_x !== want.poly_dir_x || got.poly_dir_y !== want.poly_dir_y ||
              got.circle_dir_x !== want.circle_dir_x ||
              got.circle_dir_y !== want.circle_dir_y || got.depth !== want.depth) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    contact_t res;
    int       count;
    bit       drained;
    in_item.valid = 1'b0;
    in_item.vertex_x = '0;  in_item.vertex_y = '0;  in_item.last_vertex = 1'b0;
    in_item.circle_x = '0;  in_item.circle_y = '0;  in_item.circle_radius = '0;
    in_item.poly_center_x = '0;  in_item.poly_center_y = '0;
    open_poly = 1'b0;  have_hit = 1'b0;  zero_edge = 1'b0;
    first_x = 0;  first_y = 0;  prev_x = 0;  prev_y = 0;
    circ_x = 0;  circ_y = 0;  circ_r = 0;  near_x = 0;  near_y = 0;  near_d2 = 0;
    drained = 1'b0;

    // Single-vertex polygon: the closing edge has zero length.
    res = '0;  res.degenerate_edge = 1'b1;
    add_row(mk(0, 0, 1, 5, 5, 100), 1'b1, res);
    // Zero-length edge in the middle of a polygon.
    add_row(mk(10, 10, 0, 0, 0, 1000));
    add_row(mk(10, 10, 0));
    add_row(mk(500, 0, 1), 1'b1, res);
    // Zero radius never hits: a miss with every field clear.
    res = '0;
    add_row(mk(-300, -300, 0, 0, 0, 0));
    add_row(mk(300, -300, 0));
    add_row(mk(0, 300, 1, 0, 0, 0, 7, 7), 1'b1, res);
    // Square around the centre: every edge equally near, the first one is kept.
    add_row(mk(-256, -256, 0, 0, 0, 512));
    add_row(mk(256, -256, 0));
    add_row(mk(256, 256, 0));
    add_row(mk(-256, 256, 1, 0, 0, 0, 1, -1));
    // Coordinate extremes with the largest radius.
    add_row(mk(CMAX, CMAX, 0, 0, 0, CMAX));
    add_row(mk(CMIN, CMIN, 1, 0, 0, 0, CMIN, CMAX));
    add_row(mk(CMIN, CMAX, 0, CMAX, CMIN, CMAX));
    add_row(mk(CMAX, CMIN, 0, CMIN, CMAX, 0, CMAX, CMIN));
    add_row(mk(CMAX, CMAX, 1, CMIN, CMIN, 0, CMAX, CMAX));
    // Foot past the coordinate range near a corner: contact saturates.
    add_row(mk(8388000, 8000000, 0, 8388607, 8388607, CMAX));
    add_row(mk(8388607, 8388000, 0));
    add_row(mk(8300000, 8388607, 1, 0, 0, 0, CMIN, CMIN));
    // Circle fields on later items and centre fields on earlier ones are ignored.
    add_row(mk(0, 0, 0, 100, 0, 150, CMAX, CMAX));
    add_row(mk(200, 0, 0, CMIN, CMIN, CMAX, CMIN, CMIN));
    add_row(mk(100, 200, 1, CMAX, CMAX, 1, 50, 60));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) send_vertex(table_rows[i].v, table_rows[i].fixed,
                                        table_rows[i].res);

    count = 0;
    while (count < RAND_ITEMS) begin
      // Long stretch with both sides always ready.
      if (count >= 200 && count < 300) begin
        in_idle = 0;  out_idle = 0;
      end else begin
        in_idle = 22;  out_idle = 22;
      end
      // Hold off the sender once until every expected result has come.
      if (count >= 450 && !drained && !open_poly) begin
        in_item.valid <= 1'b0;
        do @(posedge clk); while (contact_q.size() != 0);
        drained = 1'b1;
      end
      if ($urandom_range(9) < 8) begin
        send_polygon(count);
      end else begin
        // Noise: every field random, any length.
        send_vertex(mk(rnd_coord(), rnd_coord(), $urandom_range(2) == 0, rnd_coord(),
                       rnd_coord(), $urandom_range(CMAX, 0), rnd_coord(), rnd_coord()),
                    1'b0, '0);
        count++;
      end
    end
    // Close any open polygon so its result is expected.
    if (open_poly) send_vertex(mk(1, 2, 1, 0, 0, 0, 3, 4), 1'b0, '0);
    in_item.valid <= 1'b0;

    while (contact_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && contact_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
